FILE: hdl/bbvp_pkg.sv
// ----------------------------------------------------------------------------
// bbvp_pkg: shared types and constants of the basic block vector profiler
// Field widths, register indexes, the table entry key and the saturating add.
// ----------------------------------------------------------------------------
package bbvp_pkg;

  localparam int IDX_W  = 64;
  localparam int CNT_W  = 40;
  localparam int ID_W   = 6;
  localparam int SIZE_W = 4;

  localparam int DEFAULT_TABLE_ENTRIES = 32;
  localparam logic [CNT_W-1:0] INTERVAL_RESET = 40'd100000000;

  // Configuration register indexes.
  localparam logic [1:0] CFG_INTERVAL_LENGTH = 2'd0;
  localparam logic [1:0] CFG_MIN_USER        = 2'd1;
  localparam logic [1:0] CFG_WINDOW_START    = 2'd2;
  localparam logic [1:0] CFG_WINDOW_END      = 2'd3;

  // Address range of one basic block.
  typedef struct packed {
    logic [IDX_W-1:0] start_pc;
    logic [IDX_W-1:0] end_pc;
  } key_t;

  // Write strobes of the range table.
  typedef struct packed {
    logic key_we;
    logic cnt_we;
  } tbl_wr_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                              input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

  // Ascending order: start first, then end.
  function automatic logic key_less(input key_t a, input key_t b);
    return (a.start_pc < b.start_pc) ||
           ((a.start_pc == b.start_pc) && (a.end_pc < b.end_pc));
  endfunction

endpackage

FILE: hdl/bbvp_table.sv
// ----------------------------------------------------------------------------
// bbvp_table: range table storage
// Key memory and count memory with one write port and one registered read.
// ----------------------------------------------------------------------------
module bbvp_table #(
  parameter int ENTRIES = bbvp_pkg::DEFAULT_TABLE_ENTRIES,
  parameter int AW      = $clog2(ENTRIES)
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  input  bbvp_pkg::tbl_wr_t          wr,
  input  logic [AW-1:0]              wr_addr,
  input  bbvp_pkg::key_t             wr_key,
  input  logic [bbvp_pkg::CNT_W-1:0] wr_cnt,
  output bbvp_pkg::key_t             rd_key,
  output logic [bbvp_pkg::CNT_W-1:0] rd_cnt
);

  bbvp_pkg::key_t             key_mem [ENTRIES];
  logic [bbvp_pkg::CNT_W-1:0] cnt_mem [ENTRIES];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (wr.cnt_we) begin
      cnt_mem[wr_addr] <= wr_cnt;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key <= key_mem[rd_addr];
      rd_cnt <= cnt_mem[rd_addr];
    end
  end

endmodule

FILE: hdl/basic_block_vector_profiler.sv
// ----------------------------------------------------------------------------
// basic_block_vector_profiler: basic block vector collection
// Tracks the open basic block, counts ranges in a table and dumps the
// nonzero counts in ascending range order at each interval end and on a flush.
// ----------------------------------------------------------------------------
// Channel | Dir | Transfer         | Contents
// in_     | in  | tvalid & tready  | one retired instruction or a final flush
// out_    | out | tvalid & tready  | one record of an interval vector
// cfg_    | in  | cfg_we           | register index and write data
//
// An instruction that only extends the open block passes through ST_IDLE and ST_OPEN.
// A block close scans the table entries in use, reading and comparing each one.
// A dump runs one selection scan over the entries in use for each emitted record
// and one more that finds no record, then a clear pass over the entries in use;
// stalls on out_tready hold the dump.
// rst_n is synchronous; the table needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module basic_block_vector_profiler #(
  parameter int TABLE_ENTRIES = bbvp_pkg::DEFAULT_TABLE_ENTRIES
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [63:0] inst_index, [127:64] pc, [131:128] opcode_size, [132] change_of_flow,
  // [133] taken_branch, [134] has_events, [135] leaves_user_mode
  input  logic [135:0] in_tdata,
  // [0] action, [1] inst_valid
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [5:0] block_id, [45:6] block_count, [46] user_clean,
  // [110:47] interval_start, [111] interval_recorded
  output logic [111:0] out_tdata,
  // [0] block_present
  output logic         out_tuser,
  output logic         out_tlast,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [63:0]  cfg_wdata
);

  localparam int AW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW   = $clog2(TABLE_ENTRIES + 1);
  localparam int IdxW = bbvp_pkg::IDX_W;
  localparam int CntW = bbvp_pkg::CNT_W;
  localparam int IdW  = bbvp_pkg::ID_W;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b00000000001,
    ST_OPEN   = 11'b00000000010,
    ST_CL_RD  = 11'b00000000100,
    ST_CL_CMP = 11'b00000001000,
    ST_CL_FIN = 11'b00000010000,
    ST_DP_INI = 11'b00000100000,
    ST_DP_RD  = 11'b00001000000,
    ST_DP_CMP = 11'b00010000000,
    ST_DP_END = 11'b00100000000,
    ST_DP_CLR = 11'b01000000000,
    ST_RESUME = 11'b10000000000
  } state_t;

  // What follows the current close or dump.
  typedef enum logic [1:0] {
    PH_COF   = 2'd0,
    PH_TAIL  = 2'd1,
    PH_FLUSH = 2'd2
  } phase_t;

  // Configuration registers.
  logic [CntW-1:0] interval_length_r, min_user_r;
  logic [IdxW-1:0] window_start_r, window_end_r;

  // Control state.
  state_t          state_r, state_nxt;
  phase_t          phase_r, phase_nxt;
  logic [CW-1:0]   used_r, used_nxt;
  logic [CW-1:0]   scan_r, scan_nxt;
  logic [IdxW-1:0] open_start_r, open_start_nxt;
  logic [IdxW-1:0] open_end_r, open_end_nxt;
  logic [CntW-1:0] open_cnt_r, open_cnt_nxt;
  logic [CntW-1:0] ii_r, ii_nxt;
  logic            saw_r, saw_nxt;
  logic [IdxW-1:0] bmark_r, bmark_nxt;
  logic            past_r, past_nxt;
  logic            found_r, found_nxt;
  logic            have_prev_r, have_prev_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Item and scan payload.
  logic                 rec_r, rec_nxt;
  logic [IdxW-1:0]      idx_r, idx_nxt;
  logic [IdxW-1:0]      pc_r, pc_nxt;
  logic [3:0]           size_r, size_nxt;
  logic                 tbev_r, tbev_nxt;
  logic                 clean_r, clean_nxt;
  bbvp_pkg::key_t       best_key_r, best_key_nxt, prev_key_r, prev_key_nxt;
  logic [AW-1:0]        best_id_r, best_id_nxt, prev_id_r, prev_id_nxt;
  logic [CntW-1:0]      best_cnt_r, best_cnt_nxt, prev_cnt_r, prev_cnt_nxt;
  logic [111:0]         out_data_r, out_data_nxt;
  logic                 out_user_r, out_user_nxt, out_last_r, out_last_nxt;

  // Table port.
  logic                 rd_en;
  bbvp_pkg::tbl_wr_t    tbl_wr;
  logic [AW-1:0]        wr_addr;
  bbvp_pkg::key_t       wr_key, rd_key, open_key;
  logic [CntW-1:0]      wr_cnt, rd_cnt;

  // Input fields.
  logic            in_action, in_valid, in_cof, in_leaves;
  logic [IdxW-1:0] in_idx, in_pc, end_eff, new_start;
  logic            out_ok, cand;
  logic [AW:0]     emit_id;

  assign in_action = in_tuser[0];
  assign in_valid  = in_tuser[1];
  assign in_idx    = in_tdata[63:0];
  assign in_pc     = in_tdata[127:64];
  assign in_cof    = in_tdata[132];
  assign in_leaves = in_tdata[135];
  assign end_eff   = (window_end_r != '0) ? window_end_r : {IdxW{1'b1}};
  assign open_key  = '{start_pc: open_start_r, end_pc: open_end_r};
  assign new_start = (open_start_r == '0) ? pc_r : open_start_r;
  assign out_ok    = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  bbvp_table #(.ENTRIES(TABLE_ENTRIES), .AW(AW)) u_table (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_addr(scan_r[AW-1:0]),
    .wr     (tbl_wr),
    .wr_addr(wr_addr),
    .wr_key (wr_key),
    .wr_cnt (wr_cnt),
    .rd_key (rd_key),
    .rd_cnt (rd_cnt)
  );

  // Candidate for the next record: nonzero, above the last emitted key,
  // below the best key of this pass.
  assign cand = (rd_cnt != '0) &&
                (!have_prev_r || bbvp_pkg::key_less(prev_key_r, rd_key)) &&
                (!found_r || bbvp_pkg::key_less(rd_key, best_key_r));

  assign emit_id = {1'b0, prev_id_r} + 1'b1;

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    used_nxt       = used_r;
    scan_nxt       = scan_r;
    open_start_nxt = open_start_r;
    open_end_nxt   = open_end_r;
    open_cnt_nxt   = open_cnt_r;
    ii_nxt         = ii_r;
    saw_nxt        = saw_r;
    bmark_nxt      = bmark_r;
    past_nxt       = past_r;
    found_nxt      = found_r;
    have_prev_nxt  = have_prev_r;
    rec_nxt        = rec_r;
    idx_nxt        = idx_r;
    pc_nxt         = pc_r;
    size_nxt       = size_r;
    tbev_nxt       = tbev_r;
    clean_nxt      = clean_r;
    best_key_nxt   = best_key_r;
    best_id_nxt    = best_id_r;
    best_cnt_nxt   = best_cnt_r;
    prev_key_nxt   = prev_key_r;
    prev_id_nxt    = prev_id_r;
    prev_cnt_nxt   = prev_cnt_r;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    rd_en          = 1'b0;
    tbl_wr         = '0;
    wr_addr        = scan_r[AW-1:0];
    wr_key         = open_key;
    wr_cnt         = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          idx_nxt  = in_idx;
          pc_nxt   = in_pc;
          size_nxt = in_tdata[131:128];
          tbev_nxt = in_tdata[133] | in_tdata[134];
          scan_nxt = '0;
          if (in_action) begin
            // The dump still needs the user-mode flag; its clear pass drops it.
            if (ii_r != '0) begin
              phase_nxt = PH_FLUSH;
              rec_nxt   = 1'b1;
              idx_nxt   = {IdxW{1'b1}};
              state_nxt = ST_DP_INI;
            end else begin
              saw_nxt = 1'b0;
            end
          end else if (in_valid && !past_r && (in_idx >= window_start_r)) begin
            if (in_idx > end_eff) begin
              past_nxt = 1'b1;
            end else begin
              saw_nxt = saw_r | in_leaves;
              if (in_cof) begin
                phase_nxt = PH_COF;
                rec_nxt   = 1'b0;
                state_nxt = (open_start_r == '0) ? ST_OPEN : ST_CL_RD;
              end else begin
                state_nxt = ST_OPEN;
              end
            end
          end
        end
      end

      // Extend the open block by this instruction; a taken branch or event then closes it.
      ST_OPEN: begin
        open_start_nxt = new_start;
        open_end_nxt   = ((open_start_r == '0) ? pc_r : open_end_r) +
                         IdxW'(size_r);
        open_cnt_nxt   = bbvp_pkg::sat_add(open_cnt_r, CntW'(1));
        ii_nxt         = bbvp_pkg::sat_add(ii_r, CntW'(1));
        scan_nxt       = '0;
        state_nxt      = ST_IDLE;
        if (tbev_r && (new_start != '0)) begin
          phase_nxt = PH_TAIL;
          rec_nxt   = 1'b1;
          state_nxt = ST_CL_RD;
        end
      end

      // Search the table for the open range; append it when absent and the table has room.
      ST_CL_RD: begin
        if (scan_r == used_r) begin
          if (used_r < CW'(TABLE_ENTRIES)) begin
            tbl_wr   = '{key_we: 1'b1, cnt_we: 1'b1};
            wr_addr  = used_r[AW-1:0];
            wr_cnt   = open_cnt_r;
            used_nxt = used_r + 1'b1;
          end
          state_nxt = ST_CL_FIN;
        end else begin
          rd_en     = 1'b1;
          state_nxt = ST_CL_CMP;
        end
      end

      ST_CL_CMP: begin
        if (rd_key == open_key) begin
          tbl_wr    = '{key_we: 1'b0, cnt_we: 1'b1};
          wr_cnt    = bbvp_pkg::sat_add(rd_cnt, open_cnt_r);
          state_nxt = ST_CL_FIN;
        end else begin
          scan_nxt  = scan_r + 1'b1;
          state_nxt = ST_CL_RD;
        end
      end

      ST_CL_FIN: begin
        open_start_nxt = '0;
        open_end_nxt   = '0;
        open_cnt_nxt   = '0;
        state_nxt      = (ii_r >= interval_length_r) ? ST_DP_INI : ST_RESUME;
      end

      // Start a dump; an empty interval dumps nothing.
      ST_DP_INI: begin
        scan_nxt      = '0;
        found_nxt     = 1'b0;
        have_prev_nxt = 1'b0;
        if (ii_r == '0) begin
          saw_nxt   = 1'b0;
          state_nxt = ST_RESUME;
        end else begin
          clean_nxt = !(saw_r || ((idx_r != {IdxW{1'b1}}) &&
                      ((idx_r - IdxW'(ii_r)) < IdxW'(min_user_r))));
          state_nxt = ST_DP_RD;
        end
      end

      // One selection pass for the next record in ascending order.
      ST_DP_RD: begin
        if (scan_r == used_r) begin
          state_nxt = ST_DP_END;
        end else begin
          rd_en     = 1'b1;
          state_nxt = ST_DP_CMP;
        end
      end

      ST_DP_CMP: begin
        if (cand) begin
          found_nxt    = 1'b1;
          best_key_nxt = rd_key;
          best_id_nxt  = scan_r[AW-1:0];
          best_cnt_nxt = rd_cnt;
        end
        scan_nxt  = scan_r + 1'b1;
        state_nxt = ST_DP_RD;
      end

      // The held record goes out once the next one is known.
      ST_DP_END: begin
        if (out_ok && (have_prev_r || !found_r)) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = have_prev_r;
          out_last_nxt  = !found_r;
          out_data_nxt  = {rec_r, bmark_r, clean_r,
                           have_prev_r ? prev_cnt_r : {CntW{1'b0}},
                           have_prev_r ? IdW'(emit_id) : {IdW{1'b0}}};
        end
        if (found_r && (out_ok || !have_prev_r)) begin
          prev_key_nxt  = best_key_r;
          prev_id_nxt   = best_id_r;
          prev_cnt_nxt  = best_cnt_r;
          have_prev_nxt = 1'b1;
          found_nxt     = 1'b0;
          scan_nxt      = '0;
          state_nxt     = ST_DP_RD;
        end else if (!found_r && out_ok) begin
          scan_nxt  = '0;
          state_nxt = ST_DP_CLR;
        end
      end

      // Clear the interval counts.
      ST_DP_CLR: begin
        if (scan_r == used_r) begin
          if (rec_r) begin
            bmark_nxt = idx_r;
          end
          ii_nxt    = '0;
          saw_nxt   = 1'b0;
          state_nxt = ST_RESUME;
        end else begin
          tbl_wr   = '{key_we: 1'b0, cnt_we: 1'b1};
          scan_nxt = scan_r + 1'b1;
        end
      end

      ST_RESUME: begin
        state_nxt = (phase_r == PH_COF) ? ST_OPEN : ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      phase_r      <= PH_COF;
      used_r       <= '0;
      scan_r       <= '0;
      open_start_r <= '0;
      open_end_r   <= '0;
      open_cnt_r   <= '0;
      ii_r         <= '0;
      saw_r        <= 1'b0;
      bmark_r      <= '0;
      past_r       <= 1'b0;
      found_r      <= 1'b0;
      have_prev_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      used_r       <= used_nxt;
      scan_r       <= scan_nxt;
      open_start_r <= open_start_nxt;
      open_end_r   <= open_end_nxt;
      open_cnt_r   <= open_cnt_nxt;
      ii_r         <= ii_nxt;
      saw_r        <= saw_nxt;
      bmark_r      <= bmark_nxt;
      past_r       <= past_nxt;
      found_r      <= found_nxt;
      have_prev_r  <= have_prev_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rec_r      <= rec_nxt;
    idx_r      <= idx_nxt;
    pc_r       <= pc_nxt;
    size_r     <= size_nxt;
    tbev_r     <= tbev_nxt;
    clean_r    <= clean_nxt;
    best_key_r <= best_key_nxt;
    best_id_r  <= best_id_nxt;
    best_cnt_r <= best_cnt_nxt;
    prev_key_r <= prev_key_nxt;
    prev_id_r  <= prev_id_nxt;
    prev_cnt_r <= prev_cnt_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_length_r <= bbvp_pkg::INTERVAL_RESET;
      min_user_r        <= '0;
      window_start_r    <= '0;
      window_end_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        bbvp_pkg::CFG_INTERVAL_LENGTH: interval_length_r <= cfg_wdata[CntW-1:0];
        bbvp_pkg::CFG_MIN_USER:        min_user_r        <= cfg_wdata[CntW-1:0];
        bbvp_pkg::CFG_WINDOW_START:    window_start_r    <= cfg_wdata;
        bbvp_pkg::CFG_WINDOW_END:      window_end_r      <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(TABLE_ENTRIES))
    else $error("range table fill count exceeds its depth");

  a_out_from_dump: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DP_END))
    else $error("record appeared outside a dump");

  a_clear_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DP_CLR) |-> (scan_r <= used_r))
    else $error("clear pass ran past the used entries");
`endif

endmodule
